// File: rtl/core/swmc_pkg.sv
// Shared types and constants for the sliding-window median and cost block.
// Holds field widths, the cell view and control structs, and the result struct.
// Depends on nothing; every other file in rtl/core but swmc_checker imports it.
`default_nettype none

package swmc_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COST_W   = 38;
  localparam int CFG_W    = 7;
  // An age never exceeds the window length minus one, and the window length
  // is capped by the 7-bit register.
  localparam int AGE_W    = CFG_W;

  localparam logic [CFG_W-1:0] K_DEFAULT = 7'd3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COST_W-1:0]   cost_t;

  // What one cell shows its neighbors and the top level in the current cycle.
  typedef struct packed {
    logic             vld;
    logic [AGE_W-1:0] age;
    sample_t          val;
    logic             gt;
  } cell_view_t;

  // Broadcast control shared by every cell of the chain.
  typedef struct packed {
    logic             clr;
    logic             step;
    logic             flush;
    logic             full;
    sample_t          x;
    logic [AGE_W-1:0] last_age;
  } cell_ctl_t;

  typedef struct packed {
    cost_t   cost;
    sample_t median;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/swmc_if.sv
// Stream interfaces for the sample input and the result output channels.
// Each carries valid, ready and the payload fields; widths come from swmc_pkg.
`default_nettype none

interface swmc_in_if;
  import swmc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swmc_out_if;
  import swmc_pkg::*;
  logic    valid;
  logic    ready;
  cost_t   cost;
  sample_t median;
  modport source (output valid, output cost, output median, input ready);
  modport sink   (input valid, input cost, input median, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swmc_cell.sv
// One cell of the sorted window chain: a sample, its age and a valid bit.
// Removes the oldest sample and inserts the new one in a single step.
// Depends on swmc_pkg.
`default_nettype none

module swmc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  swmc_pkg::cell_ctl_t  ctl,
  input  swmc_pkg::cell_view_t left,
  input  logic                 left_rem_le,
  input  swmc_pkg::cell_view_t right,
  input  logic                 rem_le,
  output swmc_pkg::cell_view_t view,
  output logic                 del,
  output logic                 ins,
  output swmc_pkg::sample_t    held
);
  import swmc_pkg::*;

  logic             vld;
  logic [AGE_W-1:0] age;
  sample_t          val;

  cell_view_t       wv;
  cell_view_t       wl;
  logic             ins_left;
  logic             vld_next;
  logic [AGE_W-1:0] age_next;
  sample_t          val_next;

  always_comb begin
    // A restart empties the window before the new sample goes in.
    view.vld = vld & ~(ctl.step & ctl.flush);
    view.age = age;
    view.val = view.vld ? val : '0;
    view.gt  = view.vld && (val > ctl.x);
    del      = ctl.full && view.vld && (age == ctl.last_age);
    held     = val;

    // wv and wl are this slot and the left slot after the oldest is taken out.
    wv       = rem_le ? right : view;
    wl       = left_rem_le ? view : left;
    ins      = !wv.vld || wv.gt;
    ins_left = !wl.vld || wl.gt;

    if (ins_left) begin
      vld_next = wl.vld;
      age_next = wl.age + 1'b1;
      val_next = wl.val;
    end else if (ins) begin
      vld_next = 1'b1;
      age_next = '0;
      val_next = ctl.x;
    end else begin
      vld_next = wv.vld;
      age_next = wv.age + 1'b1;
      val_next = wv.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.clr) begin
      vld <= 1'b0;
    end else if (ctl.step) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      age <= age_next;
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/swmc_fifo.sv
// Small result queue that drives the output channel.
// Entries hold one result each; the write side never pushes into a full queue.
// Depends on swmc_pkg and swmc_out_if.
`default_nettype none

module swmc_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  swmc_pkg::result_t            push_data,
  swmc_out_if.source                   results,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import swmc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign results.valid  = (count != '0);
  assign results.cost   = mem[rd_ptr].cost;
  assign results.median = mem[rd_ptr].median;
  assign pop            = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_median_cost.sv
// Top level: sliding-window median and sum of absolute deviations.
// Instantiates the sorted cell chain (swmc_cell) and the result queue (swmc_fifo).
// Depends on swmc_pkg and swmc_if.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    sample[31:0], restart
//   results   out  valid/ready    cost[37:0], median[31:0]
//   cfg       in   cfg_wr_en      cfg_wr_data[6:0] (window length)
//
// One sample is taken per cycle while the input is ready; the chain of WINDOW_MAX
// cells removes the oldest sample and inserts the new one in the same cycle.
// A result passes through registers in turn after its sample: chain, delta, running sums, queue.
// Reset empties the window and sets the window length to three; a config write
// or a restart beat also empties the window.
// Outside reset, the input stalls only when the eight-entry result queue,
// counting results still in the pipeline, is full.
`default_nettype none

module sliding_window_median_cost #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [swmc_pkg::CFG_W-1:0]  cfg_wr_data,
  swmc_in_if.sink                     samples,
  swmc_out_if.source                  results
);
  import swmc_pkg::*;

  localparam int N          = WINDOW_MAX;
  localparam int IDX_W      = (N > 1) ? $clog2(N) : 1;
  localparam int WIDE_W     = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  localparam int CFG_MAX    = (1 << CFG_W) - 1;
  localparam int K_CAP      = (N > CFG_MAX) ? CFG_MAX : N;
  localparam logic [CFG_W-1:0] K_CAP_C = CFG_W'(K_CAP);
  localparam logic [CFG_W-1:0] K_RESET = (K_DEFAULT > K_CAP_C) ? K_CAP_C : K_DEFAULT;
  localparam int FIFO_DEPTH = 8;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 4);

  // Window length and fill state.
  logic [CFG_W-1:0]  k;
  logic [CFG_W-1:0]  k_wr;
  logic [CFG_W-1:0]  count;
  logic [CFG_W-1:0]  count_next;
  logic              accept;
  logic              full;
  logic              emit;
  logic [CFG_W-1:0]  nl;
  logic [CFG_W-1:0]  nlm1;
  logic [CFG_W-1:0]  mi;
  logic [WIDE_W-1:0] nl_w;
  logic [WIDE_W-1:0] nlm1_w;
  logic [WIDE_W-1:0] mi_w;
  logic [IDX_W-1:0]  nl_idx;
  logic [IDX_W-1:0]  nlm1_idx;
  logic [IDX_W-1:0]  mi_idx;

  // Cell chain.
  cell_ctl_t   ctl;
  cell_view_t  view     [N];
  cell_view_t  left_v   [N];
  cell_view_t  right_v  [N];
  sample_t     held     [N];
  logic [N-1:0] del_v;
  logic [N-1:0] ins_v;
  logic [N-1:0] rem_le_v;
  logic [N-1:0] left_rem_v;
  logic [N-1:0] low_v;

  // Values picked out of the chain for the running sums.
  sample_t     rem_val;
  logic        rem_low;
  logic        ins_low;

  // Pipeline.
  logic        s1_act, s1_emit, s1_clr, s1_pl, s1_qi;
  sample_t     s1_r, s1_vnl, s1_vnl1, s1_x;
  logic        s2_act, s2_emit, s2_clr;
  cost_t       s2_dlow, s2_dtot;
  sample_t     s2_med;
  logic        s3_emit;
  sample_t     s3_med;
  cost_t       lower;
  cost_t       total;
  cost_t       dlow_next;
  cost_t       dtot_next;
  cost_t       lose_part;
  cost_t       gain_part;
  sample_t     pushed_out;
  result_t     res;

  logic [FCNT_W-1:0] fifo_count;
  logic [CNT_W-1:0]  pending;

  // Window length bookkeeping.
  always_comb begin
    if (cfg_wr_data == '0) begin
      k_wr = CFG_W'(1);
    end else if (cfg_wr_data > K_CAP_C) begin
      k_wr = K_CAP_C;
    end else begin
      k_wr = cfg_wr_data;
    end
    nl       = k >> 1;
    nlm1     = (nl == '0) ? '0 : nl - 1'b1;
    mi       = (k - 1'b1) >> 1;
    nl_w     = WIDE_W'(nl);
    nlm1_w   = WIDE_W'(nlm1);
    mi_w     = WIDE_W'(mi);
    nl_idx   = nl_w[IDX_W-1:0];
    nlm1_idx = nlm1_w[IDX_W-1:0];
    mi_idx   = mi_w[IDX_W-1:0];
  end

  assign pending = CNT_W'(fifo_count) + CNT_W'(s1_emit) + CNT_W'(s2_emit)
                 + CNT_W'(s3_emit);
  assign samples.ready = !rst && (pending < CNT_W'(FIFO_DEPTH));
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    full = (count == k) && !samples.restart;
    if (samples.restart) begin
      count_next = CFG_W'(1);
    end else if (full) begin
      count_next = k;
    end else begin
      count_next = count + 1'b1;
    end
    emit = (count_next == k);
  end

  always_comb begin
    ctl.clr      = cfg_wr_en;
    ctl.step     = accept;
    ctl.flush    = samples.restart;
    ctl.full     = full;
    ctl.x        = samples.sample;
    ctl.last_age = AGE_W'(k - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= K_RESET;
      count <= '0;
    end else if (cfg_wr_en) begin
      k     <= k_wr;
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [N-1:0] LOW_MASK = {N{1'b1}} >> (N - 1 - i);

    // The oldest sample sits at or below this slot.
    assign rem_le_v[i] = |(del_v & LOW_MASK);
    assign low_v[i]    = (WIDE_W'(i) < nl_w);

    if (i == 0) begin : g_first
      assign left_v[i]     = '{vld: 1'b1, age: '0, val: '0, gt: 1'b0};
      assign left_rem_v[i] = 1'b0;
    end else begin : g_inner
      assign left_v[i]     = view[i-1];
      assign left_rem_v[i] = rem_le_v[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_v[i] = '0;
    end else begin : g_body
      assign right_v[i] = view[i+1];
    end

    swmc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left        (left_v[i]),
      .left_rem_le (left_rem_v[i]),
      .right       (right_v[i]),
      .rem_le      (rem_le_v[i]),
      .view        (view[i]),
      .del         (del_v[i]),
      .ins         (ins_v[i]),
      .held        (held[i])
    );
  end

  always_comb begin
    rem_val = '0;
    for (int i = 0; i < N; i++) begin
      if (del_v[i]) begin
        rem_val = rem_val | view[i].val;
      end
    end
    rem_low = |(del_v & low_v);
    ins_low = (nl != '0) && ins_v[nlm1_idx];
  end

  // Stage 1: what crosses the lower-half boundary for this beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_act  <= 1'b0;
      s1_emit <= 1'b0;
    end else begin
      s1_act  <= accept;
      s1_emit <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_clr  <= samples.restart;
      s1_pl   <= rem_low;
      s1_qi   <= ins_low;
      s1_r    <= rem_val;
      s1_vnl  <= view[nl_idx].val;
      s1_vnl1 <= view[nlm1_idx].val;
      s1_x    <= samples.sample;
    end
  end

  // Stage 2: sum deltas and the median, which the chain now holds.
  always_comb begin
    pushed_out = s1_pl ? s1_vnl : s1_vnl1;
    lose_part  = s1_pl ? (cost_t'(s1_vnl) - cost_t'(s1_r)) : '0;
    gain_part  = s1_qi ? (cost_t'(s1_x) - cost_t'(pushed_out)) : '0;
    dlow_next  = lose_part + gain_part;
    dtot_next  = cost_t'(s1_x) - cost_t'(s1_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_act  <= 1'b0;
      s2_emit <= 1'b0;
    end else begin
      s2_act  <= s1_act;
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_act) begin
      s2_clr  <= s1_clr;
      s2_dlow <= dlow_next;
      s2_dtot <= dtot_next;
      s2_med  <= held[mi_idx];
    end
  end

  // Stage 3: running sums of the lower half and of the whole window.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower   <= '0;
      total   <= '0;
      s3_emit <= 1'b0;
    end else begin
      s3_emit <= s2_emit;
      if (cfg_wr_en) begin
        lower <= '0;
        total <= '0;
      end else if (s2_act) begin
        lower <= (s2_clr ? '0 : lower) + s2_dlow;
        total <= (s2_clr ? '0 : total) + s2_dtot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_act) begin
      s3_med <= s2_med;
    end
  end

  // The cost is total - 2*lower, less the median once more for odd lengths.
  always_comb begin
    res.median = s3_med;
    res.cost   = total - (lower << 1) - (k[0] ? cost_t'(s3_med) : '0);
  end

  swmc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_emit),
    .push_data (res),
    .results   (results),
    .count     (fifo_count)
  );

endmodule

`default_nettype wire

// File: rtl/core/swmc_checker.sv
// Port-level checks for the sliding-window median block, bound to its top level.
// Watches only the handshake signals of the two channels and the reset.
`default_nettype none

module swmc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A result beat that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // The queue only fills from a sample taken earlier that has passed the pipeline stages.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc, 4))
    else $error("result appeared without a matching sample beat");

  // Right after reset nothing is pending, so the input is open.
  a_ready_after_rst: assert property (@(posedge clk)
    $fell(rst) |-> in_ready)
    else $error("input not ready after reset");

  // Backpressure needs a waiting result or a sample still in the pipeline.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid || $past(in_acc, 1) || $past(in_acc, 2)
                 || $past(in_acc, 3))
    else $error("input stalled with nothing pending");

endmodule

bind sliding_window_median_cost swmc_checker u_swmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready)
);

`default_nettype wire
